// ----- hdl/mmed_pkg.sv -----
// Shared types, codes and constants of the MIDI message event decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mmed_pkg;

   // Number of MIDI channels with stored parameter state.
   localparam int CHANNELS = 16;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Output event queue.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEND_RANGE   = 2'd1;
   localparam logic [6:0] BEND_RANGE_RESET = 7'd2;

   // Event kinds.
   localparam logic [4:0] EV_NOTE_ON   = 5'd0;
   localparam logic [4:0] EV_NOTE_OFF  = 5'd1;
   localparam logic [4:0] EV_POLY_AT   = 5'd2;
   localparam logic [4:0] EV_CC        = 5'd3;
   localparam logic [4:0] EV_PROGRAM   = 5'd4;
   localparam logic [4:0] EV_PRESSURE  = 5'd5;
   localparam logic [4:0] EV_BEND      = 5'd6;
   localparam logic [4:0] EV_RPN       = 5'd7;
   localparam logic [4:0] EV_NRPN      = 5'd8;
   localparam logic [4:0] EV_SOUND_OFF = 5'd9;
   localparam logic [4:0] EV_RESET_CTL = 5'd10;
   localparam logic [4:0] EV_NOTES_OFF = 5'd11;
   localparam logic [4:0] EV_CLOCK     = 5'd12;
   localparam logic [4:0] EV_START     = 5'd13;
   localparam logic [4:0] EV_CONTINUE  = 5'd14;
   localparam logic [4:0] EV_STOP      = 5'd15;
   localparam logic [4:0] EV_SONG_POS  = 5'd16;

   // Status high nibbles.
   localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
   localparam logic [3:0] ST_NOTE_ON   = 4'h9;
   localparam logic [3:0] ST_POLY_AT   = 4'hA;
   localparam logic [3:0] ST_CONTROL   = 4'hB;
   localparam logic [3:0] ST_PROGRAM   = 4'hC;
   localparam logic [3:0] ST_PRESSURE  = 4'hD;
   localparam logic [3:0] ST_BEND      = 4'hE;
   localparam logic [3:0] ST_SYSTEM    = 4'hF;

   // Full system status bytes.
   localparam logic [7:0] SYS_SONG_POS = 8'hF2;
   localparam logic [7:0] SYS_CLOCK    = 8'hF8;
   localparam logic [7:0] SYS_START    = 8'hFA;
   localparam logic [7:0] SYS_CONTINUE = 8'hFB;
   localparam logic [7:0] SYS_STOP     = 8'hFC;

   // Controller numbers with special handling.
   localparam logic [6:0] CC_DATA_MSB  = 7'd6;
   localparam logic [6:0] CC_DATA_LSB  = 7'd38;
   localparam logic [6:0] CC_NRPN_LSB  = 7'd98;
   localparam logic [6:0] CC_NRPN_MSB  = 7'd99;
   localparam logic [6:0] CC_RPN_LSB   = 7'd100;
   localparam logic [6:0] CC_RPN_MSB   = 7'd101;
   localparam logic [6:0] CC_SOUND_OFF = 7'd120;
   localparam logic [6:0] CC_RESET_CTL = 7'd121;
   localparam logic [6:0] CC_NOTES_OFF = 7'd123;

   localparam logic signed [14:0] BEND_CENTRE = 15'sd8192;

   // Per-channel parameter state held in the state memory.
   typedef struct packed {
      logic [13:0] rpn_number;
      logic [13:0] nrpn_number;
      logic        nrpn_selected;
      logic [6:0]  data_entry_high;
   } chan_state_type;

   localparam chan_state_type STATE_RESET = '{
      rpn_number:      14'h3FFF,
      nrpn_number:     14'h3FFF,
      nrpn_selected:   1'b0,
      data_entry_high: 7'd0
   };

   // One decoded event.
   typedef struct packed {
      logic [4:0]         event_kind;
      logic [3:0]         channel;
      logic [13:0]        number;
      logic [13:0]        value;
      logic signed [20:0] bend_semitones;
      logic               last;
   } event_type;

   // Write-back to the state memory.
   typedef struct packed {
      logic            en;
      logic [CH_W-1:0] addr;
      chan_state_type  data;
   } state_wr_type;

endpackage : mmed_pkg

`default_nettype wire

// ----- hdl/midi_message_event_decoder_core.sv -----
// MIDI message event decoder, top level: input stage, state memory, decode and event queue.
// Depends on mmed_pkg, mmed_state_mem, mmed_decode and mmed_evt_fifo.
`default_nettype none

// One assembled MIDI message is accepted per cycle while the event queue has room for
// two events. The channel's RPN/NRPN state is read from the state memory at acceptance
// and becomes available in the next cycle, when the message is decoded; when the message
// executes, its state is written back (forwarded to a read of the same channel in the
// same cycle) and zero, one or two events are queued. The first event is presented on
// the result port after the input stage registers and the event queue. The result port
// hands out one event per cycle while rsp_stall is low, so a data-entry LSB, which yields
// two events, occupies the port for both of them. The user must write configuration only
// while idle; the block itself does not enforce it.
module midi_message_event_decoder_core
   import mmed_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_status_byte,
   input  wire logic [6:0]            req_data_first,
   input  wire logic [6:0]            req_data_second,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [4:0]                 rsp_event_kind,
   output logic [3:0]                 rsp_channel,
   output logic [13:0]                rsp_number,
   output logic [13:0]                rsp_value,
   output logic signed [20:0]         rsp_bend_semitones,
   output logic                       rsp_last,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [15:0] chmask_ff;
   logic [6:0]  bend_range_ff;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [7:0]  s1_status_ff;
   logic [6:0]  s1_d1_ff;
   logic [6:0]  s1_d2_ff;

   logic           accept;
   logic           exec;
   logic           room2;
   chan_state_type cur_state;
   state_wr_type   dec_wr;
   state_wr_type   mem_wr;
   logic [1:0]     dec_count;
   logic [1:0]     push_n;
   event_type      ev0;
   event_type      ev1;
   event_type      head_ev;

   assign exec        = s1_valid_ff && room2;
   assign req_stall   = s1_valid_ff && !exec;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !exec);

   always_ff @(posedge clock) begin
      if (reset) begin
         chmask_ff     <= '0;
         bend_range_ff <= BEND_RANGE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CHANNEL_MASK: chmask_ff     <= csr_wdata[15:0];
            CSR_BEND_RANGE:   bend_range_ff <= csr_wdata[6:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= req_status_byte;
         s1_d1_ff     <= req_data_first;
         s1_d2_ff     <= req_data_second;
      end
   end

   // commit state and events only when the item executes
   always_comb begin
      mem_wr    = dec_wr;
      mem_wr.en = dec_wr.en && exec;
      push_n    = exec ? dec_count : 2'd0;
   end

   mmed_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_status_byte[CH_W-1:0]),
      .wr      (mem_wr),
      .rd_data (cur_state)
   );

   mmed_decode u_decode (
      .status_byte  (s1_status_ff),
      .data_first   (s1_d1_ff),
      .data_second  (s1_d2_ff),
      .cur          (cur_state),
      .pass_mask    (chmask_ff),
      .bend_range   (bend_range_ff),
      .evt_count    (dec_count),
      .ev0          (ev0),
      .ev1          (ev1),
      .wr           (dec_wr)
   );

   mmed_evt_fifo u_evt_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push0     (ev0),
      .push1     (ev1),
      .room2     (room2),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head_ev)
   );

   assign rsp_event_kind     = head_ev.event_kind;
   assign rsp_channel        = head_ev.channel;
   assign rsp_number         = head_ev.number;
   assign rsp_value          = head_ev.value;
   assign rsp_bend_semitones = head_ev.bend_semitones;
   assign rsp_last           = head_ev.last;

   a_no_accept_over_hold: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!s1_valid_ff || exec))
      else $error("transaction accepted over a held item");

   a_state_write_exec: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |-> (s1_valid_ff && room2 && s1_status_ff[7:4] == ST_CONTROL))
      else $error("state write outside a controller execute");

   a_held_item_stable: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !exec) |=> (s1_valid_ff && $stable(s1_status_ff)))
      else $error("held item lost");

endmodule : midi_message_event_decoder_core

`default_nettype wire

// ----- hdl/mmed_state_mem.sv -----
// Per-channel RPN/NRPN/data-entry state: synchronous memory with registered read,
// per-entry valid bits for reset values and write-to-read forwarding. Uses mmed_pkg.
`default_nettype none

module mmed_state_mem
   import mmed_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           rd_en,
   input  wire logic [CH_W-1:0] rd_addr,
   input  wire state_wr_type   wr,
   output chan_state_type      rd_data
);

   chan_state_type mem [CHANNELS];
   logic [CHANNELS-1:0] vld_ff;

   chan_state_type rd_ram_ff;
   logic           rd_vld_ff;
   logic           fwd_ff;
   chan_state_type fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   // Read port; a write to the same entry in the same cycle wins over the array.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff    <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff    <= wr.en && (wr.addr == rd_addr);
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ram_ff   <= mem[rd_addr];
         fwd_data_ff <= wr.data;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (rd_vld_ff) begin
         rd_data = rd_ram_ff;
      end else begin
         rd_data = STATE_RESET;
      end
   end

endmodule : mmed_state_mem

`default_nettype wire

// ----- hdl/mmed_decode.sv -----
// Message decode: turns one message and its channel state into up to two events
// and the state write-back. Combinational; uses mmed_pkg.
`default_nettype none

module mmed_decode
   import mmed_pkg::*;
(
   input  wire logic [7:0]     status_byte,
   input  wire logic [6:0]     data_first,
   input  wire logic [6:0]     data_second,
   input  wire chan_state_type cur,
   input  wire logic [15:0]    pass_mask,
   input  wire logic [6:0]     bend_range,
   output logic [1:0]          evt_count,
   output event_type           ev0,
   output event_type           ev1,
   output state_wr_type        wr
);

   logic [3:0]         kind;
   logic [3:0]         ch;
   logic               ch_pass;
   logic [13:0]        raw14;
   logic signed [14:0] centred;
   logic signed [22:0] bend_prod;
   logic [13:0]        d1_14;
   logic [13:0]        d2_14;
   logic [13:0]        data14;
   chan_state_type     nxt;

   assign kind      = status_byte[7:4];
   assign ch        = status_byte[3:0];
   assign ch_pass   = ({1'b0, ch} < 5'(CHANNELS)) &&
                      ((pass_mask == 16'd0) || pass_mask[ch]);
   assign raw14     = {data_second, data_first};
   assign centred   = $signed({1'b0, raw14}) - BEND_CENTRE;
   assign bend_prod = centred * $signed({1'b0, bend_range});
   assign d1_14     = {7'd0, data_first};
   assign d2_14     = {7'd0, data_second};
   assign data14    = {cur.data_entry_high, data_second};

   always_comb begin
      evt_count = 2'd0;
      ev0       = '0;
      ev1       = '0;
      nxt       = cur;
      wr.en     = 1'b0;
      wr.addr   = ch[CH_W-1:0];
      ev0.last  = 1'b1;
      ev0.channel = ch;
      ev0.number  = d1_14;
      ev0.value   = d2_14;
      ev1.last    = 1'b1;
      ev1.event_kind = EV_CC;
      ev1.channel = ch;
      ev1.number  = d1_14;
      ev1.value   = d2_14;

      if (kind == ST_SYSTEM) begin
         ev0.channel = 4'd0;
         ev0.number  = 14'd0;
         ev0.value   = 14'd0;
         evt_count   = 2'd1;
         case (status_byte)
            SYS_CLOCK:    ev0.event_kind = EV_CLOCK;
            SYS_START:    ev0.event_kind = EV_START;
            SYS_CONTINUE: ev0.event_kind = EV_CONTINUE;
            SYS_STOP:     ev0.event_kind = EV_STOP;
            SYS_SONG_POS: begin
               ev0.event_kind = EV_SONG_POS;
               ev0.value      = raw14;
            end
            default:      evt_count = 2'd0;
         endcase
      end else if (status_byte[7] && ch_pass) begin
         evt_count = 2'd1;
         case (kind)
            ST_NOTE_OFF: ev0.event_kind = EV_NOTE_OFF;
            ST_NOTE_ON:  ev0.event_kind = (data_second == 7'd0) ? EV_NOTE_OFF : EV_NOTE_ON;
            ST_POLY_AT:  ev0.event_kind = EV_POLY_AT;
            ST_PROGRAM, ST_PRESSURE: begin
               ev0.event_kind = (kind == ST_PROGRAM) ? EV_PROGRAM : EV_PRESSURE;
               ev0.number     = 14'd0;
               ev0.value      = d1_14;
            end
            ST_BEND: begin
               ev0.event_kind     = EV_BEND;
               ev0.number         = 14'd0;
               ev0.value          = raw14;
               ev0.bend_semitones = bend_prod[20:0];
            end
            ST_CONTROL: begin
               ev0.event_kind = EV_CC;
               case (data_first)
                  CC_NRPN_MSB: begin
                     nxt.nrpn_number   = {data_second, cur.nrpn_number[6:0]};
                     nxt.nrpn_selected = 1'b1;
                     wr.en             = 1'b1;
                  end
                  CC_NRPN_LSB: begin
                     nxt.nrpn_number   = {cur.nrpn_number[13:7], data_second};
                     nxt.nrpn_selected = 1'b1;
                     wr.en             = 1'b1;
                  end
                  CC_RPN_MSB: begin
                     nxt.rpn_number    = {data_second, cur.rpn_number[6:0]};
                     nxt.nrpn_selected = 1'b0;
                     wr.en             = 1'b1;
                  end
                  CC_RPN_LSB: begin
                     nxt.rpn_number    = {cur.rpn_number[13:7], data_second};
                     nxt.nrpn_selected = 1'b0;
                     wr.en             = 1'b1;
                  end
                  CC_DATA_MSB: begin
                     nxt.data_entry_high = data_second;
                     wr.en               = 1'b1;
                  end
                  CC_DATA_LSB: begin
                     // parameter event first, then the plain controller
                     evt_count      = 2'd2;
                     ev0.last       = 1'b0;
                     ev0.value      = data14;
                     ev0.event_kind = cur.nrpn_selected ? EV_NRPN : EV_RPN;
                     ev0.number     = cur.nrpn_selected ? cur.nrpn_number : cur.rpn_number;
                  end
                  CC_SOUND_OFF: ev0.event_kind = EV_SOUND_OFF;
                  CC_RESET_CTL: ev0.event_kind = EV_RESET_CTL;
                  CC_NOTES_OFF: ev0.event_kind = EV_NOTES_OFF;
                  default:      ev0.event_kind = EV_CC;
               endcase
            end
            default: evt_count = 2'd0;
         endcase
      end
      wr.data = nxt;
   end

endmodule : mmed_decode

`default_nettype wire

// ----- hdl/mmed_evt_fifo.sv -----
// Output event queue: takes up to two events per cycle, hands out one while out_stall is low.
// Uses mmed_pkg for the event type and depth.
`default_nettype none

module mmed_evt_fifo
   import mmed_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic [1:0] push_n,
   input  wire event_type push0,
   input  wire event_type push1,
   output logic           room2,
   output logic           out_valid,
   input  wire logic      out_stall,
   output event_type      out_data
);

   event_type           q_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  head_ff;
   logic [FIFO_AW-1:0]  tail_ff;
   logic [FIFO_CW-1:0]  count_ff;
   logic [FIFO_AW-1:0]  tail_nx;
   logic                pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = q_ff[head_ff];
   assign pop       = out_valid && !out_stall;
   assign room2     = (count_ff <= FIFO_CW'(FIFO_DEPTH - 2));
   assign tail_nx   = tail_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_ff[tail_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         q_ff[tail_nx] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (pop) begin
            head_ff <= head_ff + 1'b1;
         end
         tail_ff  <= tail_ff + FIFO_AW'(push_n);
         count_ff <= count_ff + FIFO_CW'(push_n) - FIFO_CW'(pop);
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CW'(FIFO_DEPTH))
      else $error("event queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> (count_ff <= FIFO_CW'(FIFO_DEPTH) - FIFO_CW'(push_n)))
      else $error("event queue overflow");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push_n == 2'd0) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("event queue count wrong after pop");

endmodule : mmed_evt_fifo

`default_nettype wire
